// File: hw/rtl/assert_macros.svh
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define FGPR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define FGPR_NEVER(lbl, cond, msg) \
  `FGPR_ASSERT(lbl, !(cond), msg)

`endif

// File: hw/rtl/fgpr_pkg.sv
`default_nettype none

package fgpr_pkg;

  localparam int unsigned DisplayWidth  = 160;
  localparam int unsigned DisplayHeight = 80;

  localparam int unsigned GlyphFirst = 32;
  localparam int unsigned GlyphLast  = 126;
  localparam int unsigned GlyphCols  = 5;
  localparam int unsigned GlyphRows  = 7;
  localparam int unsigned CellCols   = 6;
  localparam int unsigned CellRows   = 8;
  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] CharUnknown = 8'h3F;

  typedef logic [0:GlyphCols-1][GlyphRows-1:0] glyph_t;

  typedef struct packed {
    logic [7:0]  x;
    logic [7:0]  y;
    logic [2:0]  ncol;
    logic [3:0]  nrow;
    logic [15:0] fg;
    logic [15:0] bg;
    glyph_t      glyph;
  } cmd_t;

  function automatic glyph_t glyph_lookup(logic [6:0] idx);
    glyph_t g;
    unique case (idx)
      7'd0:  g = {7'h00, 7'h00, 7'h00, 7'h00, 7'h00};
      7'd1:  g = {7'h00, 7'h00, 7'h5F, 7'h00, 7'h00};
      7'd2:  g = {7'h00, 7'h07, 7'h00, 7'h07, 7'h00};
      7'd3:  g = {7'h14, 7'h7F, 7'h14, 7'h7F, 7'h14};
      7'd4:  g = {7'h24, 7'h2A, 7'h7F, 7'h2A, 7'h12};
      7'd5:  g = {7'h23, 7'h13, 7'h08, 7'h64, 7'h62};
      7'd6:  g = {7'h36, 7'h49, 7'h55, 7'h22, 7'h50};
      7'd7:  g = {7'h00, 7'h05, 7'h03, 7'h00, 7'h00};
      7'd8:  g = {7'h00, 7'h1C, 7'h22, 7'h41, 7'h00};
      7'd9:  g = {7'h00, 7'h41, 7'h22, 7'h1C, 7'h00};
      7'd10: g = {7'h14, 7'h08, 7'h3E, 7'h08, 7'h14};
      7'd11: g = {7'h08, 7'h08, 7'h3E, 7'h08, 7'h08};
      7'd12: g = {7'h00, 7'h50, 7'h30, 7'h00, 7'h00};
      7'd13: g = {7'h08, 7'h08, 7'h08, 7'h08, 7'h08};
      7'd14: g = {7'h00, 7'h60, 7'h60, 7'h00, 7'h00};
      7'd15: g = {7'h20, 7'h10, 7'h08, 7'h04, 7'h02};
      7'd16: g = {7'h3E, 7'h51, 7'h49, 7'h45, 7'h3E};
      7'd17: g = {7'h00, 7'h42, 7'h7F, 7'h40, 7'h00};
      7'd18: g = {7'h42, 7'h61, 7'h51, 7'h49, 7'h46};
      7'd19: g = {7'h21, 7'h41, 7'h45, 7'h4B, 7'h31};
      7'd20: g = {7'h18, 7'h14, 7'h12, 7'h7F, 7'h10};
      7'd21: g = {7'h27, 7'h45, 7'h45, 7'h45, 7'h39};
      7'd22: g = {7'h3C, 7'h4A, 7'h49, 7'h49, 7'h30};
      7'd23: g = {7'h01, 7'h71, 7'h09, 7'h05, 7'h03};
      7'd24: g = {7'h36, 7'h49, 7'h49, 7'h49, 7'h36};
      7'd25: g = {7'h06, 7'h49, 7'h49, 7'h29, 7'h1E};
      7'd26: g = {7'h00, 7'h36, 7'h36, 7'h00, 7'h00};
      7'd27: g = {7'h00, 7'h56, 7'h36, 7'h00, 7'h00};
      7'd28: g = {7'h08, 7'h14, 7'h22, 7'h41, 7'h00};
      7'd29: g = {7'h14, 7'h14, 7'h14, 7'h14, 7'h14};
      7'd30: g = {7'h00, 7'h41, 7'h22, 7'h14, 7'h08};
      7'd31: g = {7'h02, 7'h01, 7'h51, 7'h09, 7'h06};
      7'd32: g = {7'h32, 7'h49, 7'h79, 7'h41, 7'h3E};
      7'd33: g = {7'h7E, 7'h11, 7'h11, 7'h11, 7'h7E};
      7'd34: g = {7'h7F, 7'h49, 7'h49, 7'h49, 7'h36};
      7'd35: g = {7'h3E, 7'h41, 7'h41, 7'h41, 7'h22};
      7'd36: g = {7'h7F, 7'h41, 7'h41, 7'h22, 7'h1C};
      7'd37: g = {7'h7F, 7'h49, 7'h49, 7'h49, 7'h41};
      7'd38: g = {7'h7F, 7'h09, 7'h09, 7'h09, 7'h01};
      7'd39: g = {7'h3E, 7'h41, 7'h49, 7'h49, 7'h7A};
      7'd40: g = {7'h7F, 7'h08, 7'h08, 7'h08, 7'h7F};
      7'd41: g = {7'h00, 7'h41, 7'h7F, 7'h41, 7'h00};
      7'd42: g = {7'h20, 7'h40, 7'h41, 7'h3F, 7'h01};
      7'd43: g = {7'h7F, 7'h08, 7'h14, 7'h22, 7'h41};
      7'd44: g = {7'h7F, 7'h40, 7'h40, 7'h40, 7'h40};
      7'd45: g = {7'h7F, 7'h02, 7'h0C, 7'h02, 7'h7F};
      7'd46: g = {7'h7F, 7'h04, 7'h08, 7'h10, 7'h7F};
      7'd47: g = {7'h3E, 7'h41, 7'h41, 7'h41, 7'h3E};
      7'd48: g = {7'h7F, 7'h09, 7'h09, 7'h09, 7'h06};
      7'd49: g = {7'h3E, 7'h41, 7'h51, 7'h21, 7'h5E};
      7'd50: g = {7'h7F, 7'h09, 7'h19, 7'h29, 7'h46};
      7'd51: g = {7'h46, 7'h49, 7'h49, 7'h49, 7'h31};
      7'd52: g = {7'h01, 7'h01, 7'h7F, 7'h01, 7'h01};
      7'd53: g = {7'h3F, 7'h40, 7'h40, 7'h40, 7'h3F};
      7'd54: g = {7'h1F, 7'h20, 7'h40, 7'h20, 7'h1F};
      7'd55: g = {7'h3F, 7'h40, 7'h38, 7'h40, 7'h3F};
      7'd56: g = {7'h63, 7'h14, 7'h08, 7'h14, 7'h63};
      7'd57: g = {7'h07, 7'h08, 7'h70, 7'h08, 7'h07};
      7'd58: g = {7'h61, 7'h51, 7'h49, 7'h45, 7'h43};
      7'd59: g = {7'h00, 7'h7F, 7'h41, 7'h41, 7'h00};
      7'd60: g = {7'h02, 7'h04, 7'h08, 7'h10, 7'h20};
      7'd61: g = {7'h00, 7'h41, 7'h41, 7'h7F, 7'h00};
      7'd62: g = {7'h04, 7'h02, 7'h01, 7'h02, 7'h04};
      7'd63: g = {7'h40, 7'h40, 7'h40, 7'h40, 7'h40};
      7'd64: g = {7'h00, 7'h01, 7'h02, 7'h04, 7'h00};
      7'd65: g = {7'h20, 7'h54, 7'h54, 7'h54, 7'h78};
      7'd66: g = {7'h7F, 7'h48, 7'h44, 7'h44, 7'h38};
      7'd67: g = {7'h38, 7'h44, 7'h44, 7'h44, 7'h20};
      7'd68: g = {7'h38, 7'h44, 7'h44, 7'h48, 7'h7F};
      7'd69: g = {7'h38, 7'h54, 7'h54, 7'h54, 7'h18};
      7'd70: g = {7'h08, 7'h7E, 7'h09, 7'h01, 7'h02};
      7'd71: g = {7'h0C, 7'h52, 7'h52, 7'h52, 7'h3E};
      7'd72: g = {7'h7F, 7'h08, 7'h04, 7'h04, 7'h78};
      7'd73: g = {7'h00, 7'h44, 7'h7D, 7'h40, 7'h00};
      7'd74: g = {7'h20, 7'h40, 7'h44, 7'h3D, 7'h00};
      7'd75: g = {7'h7F, 7'h10, 7'h28, 7'h44, 7'h00};
      7'd76: g = {7'h00, 7'h41, 7'h7F, 7'h40, 7'h00};
      7'd77: g = {7'h7C, 7'h04, 7'h18, 7'h04, 7'h78};
      7'd78: g = {7'h7C, 7'h08, 7'h04, 7'h04, 7'h78};
      7'd79: g = {7'h38, 7'h44, 7'h44, 7'h44, 7'h38};
      7'd80: g = {7'h7C, 7'h14, 7'h14, 7'h14, 7'h08};
      7'd81: g = {7'h08, 7'h14, 7'h14, 7'h18, 7'h7C};
      7'd82: g = {7'h7C, 7'h08, 7'h04, 7'h04, 7'h08};
      7'd83: g = {7'h48, 7'h54, 7'h54, 7'h54, 7'h20};
      7'd84: g = {7'h04, 7'h3F, 7'h44, 7'h40, 7'h20};
      7'd85: g = {7'h3C, 7'h40, 7'h40, 7'h20, 7'h7C};
      7'd86: g = {7'h1C, 7'h20, 7'h40, 7'h20, 7'h1C};
      7'd87: g = {7'h3C, 7'h40, 7'h30, 7'h40, 7'h3C};
      7'd88: g = {7'h44, 7'h28, 7'h10, 7'h28, 7'h44};
      7'd89: g = {7'h0C, 7'h50, 7'h50, 7'h50, 7'h3C};
      7'd90: g = {7'h44, 7'h64, 7'h54, 7'h4C, 7'h44};
      7'd91: g = {7'h00, 7'h08, 7'h36, 7'h41, 7'h00};
      7'd92: g = {7'h00, 7'h00, 7'h7F, 7'h00, 7'h00};
      7'd93: g = {7'h00, 7'h41, 7'h36, 7'h08, 7'h00};
      7'd94: g = {7'h02, 7'h01, 7'h02, 7'h04, 7'h02};
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/fgpr_if.sv
`default_nettype none

interface fgpr_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  char_code;
  logic        first_of_string;
  logic [7:0]  start_x;
  logic [7:0]  start_y;
  logic [15:0] fg_color;
  logic [15:0] bg_color;

  modport source (
    output valid, char_code, first_of_string, start_x, start_y, fg_color, bg_color,
    input  ready
  );
  modport sink (
    input  valid, char_code, first_of_string, start_x, start_y, fg_color, bg_color,
    output ready
  );
endinterface

interface fgpr_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  pixel_x;
  logic [6:0]  pixel_y;
  logic [15:0] pixel_color;
  logic        last_pixel;

  modport source (
    output valid, pixel_x, pixel_y, pixel_color, last_pixel,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, pixel_color, last_pixel,
    output ready
  );
endinterface

`default_nettype wire

// File: hw/rtl/fgpr_front.sv
`default_nettype none
`include "assert_macros.svh"

module fgpr_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  fgpr_in_if.sink       in_i,
  output logic          push_valid_o,
  output fgpr_pkg::cmd_t push_cmd_o,
  input  logic          push_ready_i
);
  import fgpr_pkg::*;

  logic [8:0] cursor_q, cursor_d;
  logic [7:0] row_q, row_d;
  logic       stopped_q, stopped_d;

  logic       accept;
  logic [8:0] cur;
  logic [7:0] row;
  logic       stopped;
  logic [8:0] cur_next;
  logic [8:0] rem_x;
  logic [8:0] rem_y;
  logic [2:0] ncol;
  logic [3:0] nrow;
  logic [7:0] code;
  logic [6:0] idx;

  assign in_i.ready = push_ready_i;
  assign accept     = in_i.valid && in_i.ready;

  // string start overrides the running cursor
  always_comb begin
    if (in_i.first_of_string) begin
      cur     = {1'b0, in_i.start_x};
      row     = in_i.start_y;
      stopped = (in_i.start_y >= 8'(DisplayHeight));
    end else begin
      cur     = cursor_q;
      row     = row_q;
      stopped = stopped_q;
    end
  end

  assign cur_next = cur + 9'(CellCols);
  assign rem_x    = 9'(DisplayWidth) - cur;
  assign rem_y    = 9'(DisplayHeight) - {1'b0, row};

  // visible part of the cell is a rectangle from its top left corner
  always_comb begin
    if (cur >= 9'(DisplayWidth)) begin
      ncol = 3'd0;
    end else if (rem_x >= 9'(CellCols)) begin
      ncol = 3'(CellCols);
    end else begin
      ncol = rem_x[2:0];
    end
    if (stopped) begin
      nrow = 4'd0;
    end else if (rem_y >= 9'(CellRows)) begin
      nrow = 4'(CellRows);
    end else begin
      nrow = rem_y[3:0];
    end
  end

  always_comb begin
    if (in_i.char_code < 8'(GlyphFirst) || in_i.char_code > 8'(GlyphLast)) begin
      code = CharUnknown;
    end else begin
      code = in_i.char_code;
    end
  end

  assign idx = 7'(code - 8'(GlyphFirst));

  assign push_valid_o     = accept && !stopped && (ncol != 3'd0);
  assign push_cmd_o.x     = cur[7:0];
  assign push_cmd_o.y     = row;
  assign push_cmd_o.ncol  = ncol;
  assign push_cmd_o.nrow  = nrow;
  assign push_cmd_o.fg    = in_i.fg_color;
  assign push_cmd_o.bg    = in_i.bg_color;
  assign push_cmd_o.glyph = glyph_lookup(idx);

  always_comb begin
    cursor_d  = cursor_q;
    row_d     = row_q;
    stopped_d = stopped_q;
    if (accept) begin
      row_d = row;
      if (stopped) begin
        cursor_d  = cur;
        stopped_d = 1'b1;
      end else begin
        cursor_d  = cur_next;
        stopped_d = (cur_next >= 9'(DisplayWidth));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q  <= '0;
      row_q     <= '0;
      stopped_q <= 1'b1;
    end else begin
      cursor_q  <= cursor_d;
      row_q     <= row_d;
      stopped_q <= stopped_d;
    end
  end

  `FGPR_ASSERT(row_on_screen_a, !stopped_q |-> (row_q < 8'(DisplayHeight)),
               "active row off screen")
  `FGPR_ASSERT(cursor_on_screen_a, !stopped_q |-> (cursor_q < 9'(DisplayWidth)),
               "active cursor off screen")
  `FGPR_NEVER(empty_push_a, push_valid_o && (push_cmd_o.nrow == 4'd0), "push of empty cell")

endmodule

`default_nettype wire

// File: hw/rtl/fgpr_queue.sv
`default_nettype none
`include "assert_macros.svh"

module fgpr_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  input  fgpr_pkg::cmd_t push_cmd_i,
  output logic           push_ready_o,
  output logic           pop_valid_o,
  output fgpr_pkg::cmd_t pop_cmd_o,
  input  logic           pop_ready_i
);
  import fgpr_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);

  cmd_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]   count_q, count_d;
  logic            push;
  logic            pop;

  assign push_ready_o = (count_q != (PtrW+1)'(QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_cmd_o    = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  `FGPR_ASSERT(count_bound_a, count_q <= (PtrW+1)'(QueueDepth), "queue overfilled")
  `FGPR_ASSERT(ptr_gap_a, (count_q == '0) |-> (wr_ptr_q == rd_ptr_q), "pointers disagree when empty")

endmodule

`default_nettype wire

// File: hw/rtl/fgpr_back.sv
`default_nettype none
`include "assert_macros.svh"

module fgpr_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           pop_valid_i,
  input  fgpr_pkg::cmd_t pop_cmd_i,
  output logic           pop_ready_o,
  fgpr_out_if.source     out_o
);
  import fgpr_pkg::*;

  cmd_t        cmd_q, cmd_d;
  logic        busy_q, busy_d;
  logic [2:0]  col_q, col_d;
  logic [2:0]  row_q, row_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  px_q, px_d;
  logic [6:0]  py_q, py_d;
  logic [15:0] color_q, color_d;
  logic        last_q, last_d;

  logic        advance;
  logic        col_end;
  logic        row_end;
  logic        is_last;
  logic        bit_set;
  logic [6:0]  py_full;

  assign advance     = busy_q && (!out_valid_q || out_o.ready);
  assign row_end     = ({1'b0, row_q} == cmd_q.nrow - 4'd1);
  assign col_end     = (col_q == cmd_q.ncol - 3'd1);
  assign is_last     = col_end && row_end;
  assign pop_ready_o = !busy_q || (advance && is_last);

  // gap column and bottom row are background
  always_comb begin
    if (col_q < 3'(GlyphCols) && row_q < 3'(GlyphRows)) begin
      bit_set = cmd_q.glyph[col_q][row_q];
    end else begin
      bit_set = 1'b0;
    end
  end

  assign py_full = 7'(cmd_q.y + {5'd0, row_q});

  always_comb begin
    cmd_d       = cmd_q;
    busy_d      = busy_q;
    col_d       = col_q;
    row_d       = row_q;
    out_valid_d = out_valid_q;
    px_d        = px_q;
    py_d        = py_q;
    color_d     = color_q;
    last_d      = last_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (advance) begin
      out_valid_d = 1'b1;
      px_d        = cmd_q.x + {5'd0, col_q};
      py_d        = py_full;
      color_d     = bit_set ? cmd_q.fg : cmd_q.bg;
      last_d      = is_last;
      if (is_last) begin
        busy_d = 1'b0;
      end else if (row_end) begin
        row_d = '0;
        col_d = col_q + 3'd1;
      end else begin
        row_d = row_q + 3'd1;
      end
    end
    if (pop_valid_i && pop_ready_o) begin
      cmd_d  = pop_cmd_i;
      busy_d = 1'b1;
      col_d  = '0;
      row_d  = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    px_q    <= px_d;
    py_q    <= py_d;
    color_q <= color_d;
    last_q  <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      col_q       <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      col_q       <= col_d;
      row_q       <= row_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.pixel_x     = px_q;
  assign out_o.pixel_y     = py_q;
  assign out_o.pixel_color = color_q;
  assign out_o.last_pixel  = last_q;

  `FGPR_ASSERT(walk_bound_a,
               busy_q |-> ((col_q < cmd_q.ncol) && ({1'b0, row_q} < cmd_q.nrow)),
               "walk past visible cell")
  `FGPR_ASSERT(last_ends_a, (advance && is_last && !pop_valid_i) |=> !busy_q,
               "busy after final pixel")

endmodule

`default_nettype wire

// File: hw/rtl/font_glyph_pixel_rasterizer_core.sv
// 5x7 font character generator for a 160x80 RGB565 panel.
// in_i takes one character per beat with its string start position (used when
// first_of_string is set) and its foreground and background colours.
// out_o gives one pixel per beat: column, row, colour, and last_pixel on the
// final pixel of a character. Pixels of the 6x8 cell come column by column,
// row 0 first; pixels off the panel are dropped, and a character with none
// visible gives no beat at all.
// The first pixel leaves once its character has passed the command queue,
// the walker's command register and the output register. The walker gives one
// pixel per cycle while out_o does not stall, 48 for a full cell and only the
// visible ones for a clipped cell. A two-entry command queue in front of the
// walker lets up to two further characters be taken while one is drawn; ones
// with nothing to draw are taken one per cycle while the queue has room.
// Reset empties the queue, drops the output valid and leaves no string active.
// When out_o stalls, the pixel is held in the output register, the walker
// stops, and in_i keeps accepting until the queue fills.
`default_nettype none

module font_glyph_pixel_rasterizer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  fgpr_in_if.sink    in_i,
  fgpr_out_if.source out_o
);
  import fgpr_pkg::*;

  logic push_valid;
  cmd_t push_cmd;
  logic push_ready;
  logic pop_valid;
  cmd_t pop_cmd;
  logic pop_ready;

  fgpr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_cmd_o   (push_cmd),
    .push_ready_i (push_ready)
  );

  fgpr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_cmd_i   (push_cmd),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_cmd_o    (pop_cmd),
    .pop_ready_i  (pop_ready)
  );

  fgpr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_cmd_i   (pop_cmd),
    .pop_ready_o (pop_ready),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import fgpr_pkg::*;

  typedef struct {
    logic [7:0]  x;
    logic [6:0]  y;
    logic [15:0] colour;
    logic        last;
  } pixel_t;

  typedef enum int {SinkFree, SinkRandom, SinkPeriodic, SinkLongStall} sink_mode_e;

  localparam int unsigned CycleLimit = 3_000_000;
  localparam int unsigned ItemGoal   = 410;

  // five glyph columns per entry, leftmost column in the top byte
  localparam logic [39:0] FontRom [95] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14, 40'h242A7F2A12,
    40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001C224100, 40'h0041221C00,
    40'h14083E0814, 40'h08083E0808, 40'h0050300000, 40'h0808080808, 40'h0060600000,
    40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503, 40'h3649494936,
    40'h064949291E, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
    40'h0041221408, 40'h0201510906, 40'h324979413E, 40'h7E1111117E, 40'h7F49494936,
    40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
    40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
    40'h7F09192946, 40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
    40'h3F4038403F, 40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
    40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040, 40'h0001020400,
    40'h2054545478, 40'h7F48444438, 40'h3844444420, 40'h384444487F, 40'h3854545418,
    40'h087E090102, 40'h0C5252523E, 40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
    40'h7F10284400, 40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
    40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420, 40'h043F444020,
    40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
    40'h4464544C44, 40'h0008364100, 40'h00007F0000, 40'h0041360800, 40'h0201020402
  };

  logic clk_i;
  logic rst_ni;

  fgpr_in_if  in_if ();
  fgpr_out_if out_if ();

  font_glyph_pixel_rasterizer_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  pixel_t      expected_pixels[$];
  logic [8:0]  cursor_col;
  logic [7:0]  text_row;
  logic        text_stopped;
  int unsigned mismatch_count;
  int unsigned chars_sent;
  int unsigned cycle_count;
  int unsigned burst_left;
  bit          sender_gaps;
  sink_mode_e  sink_mode;
  int unsigned sink_cycles;
  int unsigned stall_left;

  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // works out the pixels one character gives and advances the text cursor
  function automatic void raster_char(input logic [7:0] code, input logic first,
                                      input logic [7:0] sx, input logic [7:0] sy,
                                      input logic [15:0] fg, input logic [15:0] bg);
    int unsigned glyph_code;
    int unsigned px;
    int unsigned py;
    int unsigned count;
    logic [39:0] cols;
    logic [7:0]  bits;
    pixel_t      pix;
    if (first) begin
      cursor_col   = {1'b0, sx};
      text_row     = sy;
      text_stopped = sy >= DisplayHeight;
    end
    if (text_stopped) return;
    glyph_code = code;
    if (glyph_code < GlyphFirst || glyph_code > GlyphLast) glyph_code = CharUnknown;
    cols  = FontRom[glyph_code - GlyphFirst];
    count = 0;
    for (int c = 0; c < CellCols; c++) begin
      bits = (c < GlyphCols) ? 8'(cols >> (8 * (GlyphCols - 1 - c))) : 8'h00;
      px   = cursor_col + c;
      for (int r = 0; r < CellRows; r++) begin
        py = text_row + r;
        if (px < DisplayWidth && py < DisplayHeight) begin
          pix.x      = 8'(px);
          pix.y      = 7'(py);
          pix.colour = bits[r] ? fg : bg;
          pix.last   = 1'b0;
          expected_pixels.push_back(pix);
          count++;
        end
      end
    end
    if (count != 0) begin
      pix      = expected_pixels.pop_back();
      pix.last = 1'b1;
      expected_pixels.push_back(pix);
    end
    cursor_col = cursor_col + 9'(CellCols);
    if (cursor_col >= DisplayWidth) text_stopped = 1'b1;
  endfunction

  task automatic send_char(input logic [7:0] code, input logic first,
                           input logic [7:0] sx, input logic [7:0] sy,
                           input logic [15:0] fg, input logic [15:0] bg);
    in_if.char_code       = code;
    in_if.first_of_string = first;
    in_if.start_x         = sx;
    in_if.start_y         = sy;
    in_if.fg_color        = fg;
    in_if.bg_color        = bg;
    in_if.valid           = 1'b1;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    raster_char(code, first, sx, sy, fg, bg);
    chars_sent++;
    @(negedge clk_i);
    if (burst_left != 0) begin
      burst_left--;
    end else if (sender_gaps) begin
      in_if.valid = 1'b0;
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(20, 70)) @(negedge clk_i);
      else repeat ($urandom_range(1, 8)) @(negedge clk_i);
      burst_left = $urandom_range(0, 10);
    end
  endtask

  task automatic wait_pixels_drained();
    in_if.valid = 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // pixel beats are checked against the oldest expectation
  always @(posedge clk_i) begin : check_pixels
    pixel_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel (%0d,%0d) colour %h last %b",
                                  out_if.pixel_x, out_if.pixel_y, out_if.pixel_color,
                                  out_if.last_pixel));
      end else begin
        want = expected_pixels.pop_front();
        if (out_if.pixel_x !== want.x || out_if.pixel_y !== want.y ||
            out_if.pixel_color !== want.colour || out_if.last_pixel !== want.last) begin
          report_mismatch($sformatf("pixel (%0d,%0d) colour %h last %b, want (%0d,%0d) %h %b",
                                    out_if.pixel_x, out_if.pixel_y, out_if.pixel_color,
                                    out_if.last_pixel, want.x, want.y, want.colour,
                                    want.last));
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (sink_cycles == 0) begin
      sink_mode   = sink_mode_e'($urandom_range(0, 3));
      sink_cycles = $urandom_range(50, 250);
    end else begin
      sink_cycles--;
    end
    if (stall_left != 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else begin
      case (sink_mode)
        SinkFree:     out_if.ready <= 1'b1;
        SinkRandom:   out_if.ready <= $urandom_range(0, 9) >= 3;
        SinkPeriodic: out_if.ready <= (sink_cycles % 5) >= 2;
        default: begin
          if ($urandom_range(0, 15) == 0) begin
            stall_left = $urandom_range(1, 19);
            out_if.ready <= 1'b0;
          end else begin
            out_if.ready <= 1'b1;
          end
        end
      endcase
    end
  end

  task automatic test_directed();
    sender_gaps = 1'b0;
    // no string active yet
    send_char(8'h41, 1'b0, 8'hAB, 8'hCD, 16'hFFFF, 16'h0000);
    send_char(8'h41, 1'b1, 8'd0, 8'd0, 16'hFFFF, 16'h0000);
    send_char(8'h20, 1'b0, 8'hFF, 8'hFF, 16'h0000, 16'hFFFF);
    send_char(8'h7E, 1'b0, 8'h00, 8'h00, 16'hA5A5, 16'h5A5A);
    // codes outside the font fall back to a question mark
    send_char(8'h00, 1'b0, 8'h00, 8'h00, 16'h5A5A, 16'hA5A5);
    send_char(8'h7F, 1'b0, 8'h00, 8'h00, 16'h1234, 16'hFEDC);
    send_char(8'hFF, 1'b0, 8'h00, 8'h00, 16'hFFFF, 16'h0000);
    send_char(8'h1F, 1'b0, 8'h00, 8'h00, 16'h0000, 16'hFFFF);
    send_char(8'h3F, 1'b0, 8'h00, 8'h00, 16'h8001, 16'h7FFE);
    send_char(8'h80, 1'b0, 8'h00, 8'h00, 16'hF800, 16'h07E0);
    // right edge: full cell then stop, partial cell then stop
    send_char(8'h40, 1'b1, 8'd154, 8'd10, 16'h001F, 16'hF800);
    send_char(8'h42, 1'b0, 8'd0, 8'd0, 16'h001F, 16'hF800);
    send_char(8'h43, 1'b1, 8'd156, 8'd20, 16'h07E0, 16'h001F);
    send_char(8'h44, 1'b0, 8'd0, 8'd0, 16'h07E0, 16'h001F);
    // bottom edge
    send_char(8'h45, 1'b1, 8'd40, 8'd76, 16'hFFFF, 16'h0000);
    send_char(8'h46, 1'b0, 8'd0, 8'd0, 16'hFFFF, 16'h0000);
    // row off screen, column off screen
    send_char(8'h47, 1'b1, 8'd10, 8'd80, 16'hFFFF, 16'h0000);
    send_char(8'h48, 1'b0, 8'd10, 8'd10, 16'hFFFF, 16'h0000);
    send_char(8'h49, 1'b1, 8'd160, 8'd0, 16'hFFFF, 16'h0000);
    send_char(8'h4A, 1'b0, 8'd0, 8'd0, 16'hFFFF, 16'h0000);
    send_char(8'h4B, 1'b1, 8'd255, 8'd255, 16'hFFFF, 16'hFFFF);
    // single visible pixel in the corner
    send_char(8'h4C, 1'b1, 8'd159, 8'd79, 16'hFFFF, 16'h0000);
    send_char(8'h4D, 1'b1, 8'd0, 8'd72, 16'h0000, 16'hFFFF);
    send_char(8'h7B, 1'b0, 8'd0, 8'd0, 16'hFFFF, 16'h0000);
  endtask

  task automatic test_pause_until_drained();
    sender_gaps = 1'b1;
    send_char(8'h48, 1'b1, 8'd60, 8'd30, 16'hFFE0, 16'h0010);
    send_char(8'h69, 1'b0, 8'd0, 8'd0, 16'hFFE0, 16'h0010);
    wait_pixels_drained();
    // cursor must survive the idle spell
    send_char(8'h21, 1'b0, 8'd0, 8'd0, 16'hFFE0, 16'h0010);
    wait_pixels_drained();
  endtask

  task automatic test_random_text();
    int unsigned len;
    logic [7:0]  sx;
    logic [7:0]  sy;
    logic [7:0]  code;
    logic [15:0] fg;
    logic [15:0] bg;
    while (chars_sent < ItemGoal) begin
      if ($urandom_range(0, 4) == 0) sender_gaps = !sender_gaps;
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          send_char(8'($urandom), 1'($urandom), 8'($urandom), 8'($urandom),
                    16'($urandom), 16'($urandom));
        end
      end else begin
        case ($urandom_range(0, 5))
          0:       sx = 8'($urandom);
          1:       sx = 8'($urandom_range(140, DisplayWidth - 1));
          default: sx = 8'($urandom_range(0, DisplayWidth - 1));
        endcase
        case ($urandom_range(0, 5))
          0:       sy = 8'($urandom);
          1:       sy = 8'($urandom_range(70, DisplayHeight - 1));
          default: sy = 8'($urandom_range(0, DisplayHeight - 1));
        endcase
        fg  = 16'($urandom);
        bg  = 16'($urandom);
        len = $urandom_range(1, 30);
        for (int i = 0; i < len && chars_sent < ItemGoal; i++) begin
          code = ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                             : 8'($urandom_range(GlyphFirst, GlyphLast));
          if (i == 0) send_char(code, 1'b1, sx, sy, fg, bg);
          else send_char(code, 1'b0, 8'($urandom), 8'($urandom),
                         ($urandom_range(0, 7) == 0) ? 16'($urandom) : fg, bg);
        end
      end
    end
  endtask

  initial begin
    rst_ni                = 1'b0;
    in_if.valid           = 1'b0;
    in_if.char_code       = '0;
    in_if.first_of_string = 1'b0;
    in_if.start_x         = '0;
    in_if.start_y         = '0;
    in_if.fg_color        = '0;
    in_if.bg_color        = '0;
    out_if.ready          = 1'b0;
    mismatch_count        = 0;
    chars_sent            = 0;
    cycle_count           = 0;
    burst_left            = 0;
    sender_gaps           = 1'b0;
    sink_mode             = SinkFree;
    sink_cycles           = 0;
    stall_left            = 0;
    cursor_col            = '0;
    text_row              = '0;
    text_stopped          = 1'b1;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    wait_pixels_drained();
    test_pause_until_drained();
    test_random_text();
    wait_pixels_drained();
    repeat (100) @(posedge clk_i);

    if (mismatch_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/fgpr_pkg.sv
hw/rtl/fgpr_if.sv
hw/rtl/fgpr_front.sv
hw/rtl/fgpr_queue.sv
hw/rtl/fgpr_back.sv
hw/rtl/font_glyph_pixel_rasterizer_core.sv
sim/tb_top.sv
